/* hdl/ordered_list_queue_with_erase_defines.svh */
`ifndef ORDERED_LIST_QUEUE_WITH_ERASE_DEFINES_SVH
`define ORDERED_LIST_QUEUE_WITH_ERASE_DEFINES_SVH

`ifndef SYNTH
// pre holds in a cycle -> post holds in the same cycle
`define OLQ_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("olq check failed");
// pre holds in a cycle -> post holds in the next cycle
`define OLQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("olq check failed");
`else
`define OLQ_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define OLQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* hdl/olq_pkg.sv */
`timescale 1ns / 1ps

package olq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned ActionW   = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountW    = $clog2(Depth + 1);
  localparam int unsigned InTdataW  = 32;
  // popped, match count, occupancy, empty flag, front, back
  localparam int unsigned OutUsedW  = ValueW + CountW + CountW + 1 + ValueW + ValueW;
  localparam int unsigned OutTdataW = ((OutUsedW + 7) / 8) * 8;
  localparam int unsigned OutPadW   = OutTdataW - OutUsedW;

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_BACK   = 3'd0,
    ACT_PUSH_FRONT  = 3'd1,
    ACT_POP_FRONT   = 3'd2,
    ACT_ERASE_EQUAL = 3'd3,
    ACT_COUNT_EQUAL = 3'd4
  } action_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

endpackage

/* hdl/ordered_list_queue_with_erase.sv */
// Ordered store of up to DEPTH values kept as a ring in a single-port-write, registered-read
// memory. Each request carries an action in s_axis_tuser and a value in s_axis_tdata and gives
// exactly one result. A sequencer drives one read port and one compare unit: push, pop and the
// unused action codes step through S_FRONT, S_BACK and S_OUT, while erase or count first walk
// the stored entries one per cycle in S_SCAN. The block takes no new request until the
// current one has moved into the output register, which holds it until the consumer takes it;
// a full output register keeps the request in S_OUT until the consumer takes the result.
`timescale 1ns / 1ps
`include "ordered_list_queue_with_erase_defines.svh"

module ordered_list_queue_with_erase (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] item_value
  input  logic [olq_pkg::InTdataW-1:0]    s_axis_tdata,
  // [2:0] action
  input  logic [olq_pkg::ActionW-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] popped_value, [36:32] match_count, [41:37] occupancy, [42] is_empty,
  // [74:43] front_value, [106:75] back_value, [111:107] zero
  output logic [olq_pkg::OutTdataW-1:0]   m_axis_tdata,
  // [1:0] status
  output logic [olq_pkg::StatusW-1:0]     m_axis_tuser
);

  localparam int unsigned DEPTH      = olq_pkg::Depth;
  localparam int unsigned DATA_WIDTH = olq_pkg::ValueW;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FRONT = 5'b00100,
    S_BACK  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  state_e                 state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          keep_q, keep_d;
  logic [CW-1:0]          match_q, match_d;
  logic                   pend_q, pend_d;
  olq_pkg::status_e       status_q, status_d;
  olq_pkg::action_e       act_q, act_d;
  logic [DATA_WIDTH-1:0]  val_q;
  logic [DATA_WIDTH-1:0]  rd_data_q;
  logic [DATA_WIDTH-1:0]  popped_q;
  logic [DATA_WIDTH-1:0]  front_q;

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic                   we;
  logic                   out_load;

  logic                   m_valid_q;
  olq_pkg::status_e       m_status_q;
  logic [olq_pkg::ValueW-1:0] m_popped_q;
  logic [olq_pkg::CountW-1:0] m_match_q;
  logic [olq_pkg::CountW-1:0] m_occ_q;
  logic                       m_empty_q;
  logic [olq_pkg::ValueW-1:0] m_front_q;
  logic [olq_pkg::ValueW-1:0] m_back_q;

  olq_pkg::action_e       in_action;
  logic [DATA_WIDTH-1:0]  in_value;
  logic [AW-1:0]          head_dec;
  logic                   is_full;
  logic                   accept;

  assign in_action     = olq_pkg::action_e'(s_axis_tuser);
  assign in_value      = DATA_WIDTH'(s_axis_tdata[olq_pkg::ValueW-1:0]);
  assign head_dec      = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign is_full       = (count_q == CW'(DEPTH));
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    idx_d    = idx_q;
    keep_d   = keep_q;
    match_d  = match_q;
    pend_d   = pend_q;
    status_d = status_q;
    act_d    = act_q;
    rd_addr  = head_q;
    we       = 1'b0;
    wr_addr  = head_q;
    wr_data  = in_value;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d    = in_action;
          status_d = olq_pkg::STAT_OK;
          idx_d    = '0;
          keep_d   = '0;
          match_d  = '0;
          pend_d   = 1'b0;
          state_d  = S_FRONT;
          case (in_action)
            olq_pkg::ACT_PUSH_BACK: begin
              if (is_full) begin
                status_d = olq_pkg::STAT_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = slot(head_q, count_q);
                count_d = count_q + CW'(1);
              end
            end
            olq_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                status_d = olq_pkg::STAT_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = head_dec;
                head_d  = head_dec;
                count_d = count_q + CW'(1);
              end
            end
            olq_pkg::ACT_POP_FRONT: begin
              // old head is read this cycle and picked up in S_FRONT
              if (count_q == '0) begin
                status_d = olq_pkg::STAT_EMPTY;
              end else begin
                head_d  = slot(head_q, CW'(1));
                count_d = count_q - CW'(1);
              end
            end
            olq_pkg::ACT_ERASE_EQUAL, olq_pkg::ACT_COUNT_EQUAL: begin
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // read entry idx while comparing the one fetched last cycle
        if (idx_q < count_q) begin
          rd_addr = slot(head_q, idx_q);
          idx_d   = idx_q + CW'(1);
          pend_d  = 1'b1;
        end else begin
          pend_d  = 1'b0;
        end
        if (pend_q) begin
          if (rd_data_q == val_q) begin
            match_d = match_q + CW'(1);
          end else begin
            keep_d = keep_q + CW'(1);
            if (act_q == olq_pkg::ACT_ERASE_EQUAL) begin
              // compaction: keep slot always trails the read slot
              we      = 1'b1;
              wr_addr = slot(head_q, keep_q);
              wr_data = rd_data_q;
            end
          end
        end
        if (idx_q >= count_q) begin
          state_d = S_FRONT;
          if (act_q == olq_pkg::ACT_ERASE_EQUAL) count_d = keep_d;
        end
      end
      S_FRONT: begin
        rd_addr = head_q;
        state_d = S_BACK;
      end
      S_BACK: begin
        rd_addr = slot(head_q, count_q - CW'(1));
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold the tail read so rd_data_q stays put while stalled
        rd_addr = slot(head_q, count_q - CW'(1));
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      keep_q   <= '0;
      match_q  <= '0;
      pend_q   <= 1'b0;
      status_q <= olq_pkg::STAT_OK;
      act_q    <= olq_pkg::ACT_PUSH_BACK;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      keep_q   <= keep_d;
      match_q  <= match_d;
      pend_q   <= pend_d;
      status_q <= status_d;
      act_q    <= act_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) val_q <= in_value;
    if (state_q == S_FRONT) begin
      popped_q <= (act_q == olq_pkg::ACT_POP_FRONT && status_q == olq_pkg::STAT_OK) ?
                  rd_data_q : '0;
    end
    if (state_q == S_BACK) front_q <= rd_data_q;
    if (out_load) begin
      m_status_q <= status_q;
      m_popped_q <= olq_pkg::ValueW'(popped_q);
      m_match_q  <= olq_pkg::CountW'(match_q);
      m_occ_q    <= olq_pkg::CountW'(count_q);
      m_empty_q  <= (count_q == '0);
      m_front_q  <= (count_q == '0) ? '0 : olq_pkg::ValueW'(front_q);
      m_back_q   <= (count_q == '0) ? '0 : olq_pkg::ValueW'(rd_data_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{olq_pkg::OutPadW{1'b0}}, m_back_q, m_front_q, m_empty_q,
                          m_occ_q, m_match_q, m_popped_q};

  `OLQ_ASSERT_IMP(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH))
  `OLQ_ASSERT_IMP(a_head_in_range, clk_i, rst_ni, 1'b1, 32'(head_q) < DEPTH)
  `OLQ_ASSERT_IMP(a_scan_tally, clk_i, rst_ni, state_q == S_SCAN, match_q + keep_q + CW'(pend_q) == idx_q)
  `OLQ_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
